[src/rgcd_pkg.sv]
// shared types and constants for the rational alu with gcd reduction
package rgcd_pkg;

    localparam int MODE_W = 3;
    localparam int NUM_W  = 33;
    localparam int DEN_W  = 32;

    typedef logic [MODE_W-1:0] t_mode;

    // operation codes; unused codes behave as a plain reduce of the first fraction
    localparam t_mode MODE_ADD = 3'd0;
    localparam t_mode MODE_MUL = 3'd1;
    localparam t_mode MODE_EQ  = 3'd2;
    localparam t_mode MODE_INC = 3'd3;

endpackage

[src/rational_alu_gcd_reduce_core.sv]
// rational fraction alu: add, multiply, compare, increment, reduce, with gcd reduction
//
// Takes one word of two fractions (a_num/a_den, b_num/b_den) plus a mode and returns one
// reduced fraction per word. Work runs through a small sequencer around one shared
// OPERAND_WIDTH x OPERAND_WIDTH multiplier and one shared subtractor. Steps per word:
// accept, two or three products (add: three, multiply/equality: two, others: none), one
// check step, a binary gcd that does one halving, swap or subtract per cycle, then two
// restoring divisions that build IW-bit quotients (IW = 2*OPERAND_WIDTH+1, capped at 64,
// so 33 at the default width), and a load of the output register. A zero numerator or
// denominator skips the gcd and divisions entirely. The gcd loop and the division steps
// both run on the shared subtractor. The input side is ready only while the sequencer is
// idle. A finished word sits in an output register, so a new word may be accepted and
// computed while the previous result waits for the consumer. Equality compares cross
// products of the inputs (exact, and equivalent to comparing reduced forms), with
// fractions that cannot be reduced compared as given; the result fields then carry the
// reduced first fraction.
module rational_alu_gcd_reduce_core #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  rgcd_pkg::t_mode               i_mode,
    input  logic [OPERAND_WIDTH-1:0]      i_a_num,
    input  logic [OPERAND_WIDTH-1:0]      i_a_den,
    input  logic [OPERAND_WIDTH-1:0]      i_b_num,
    input  logic [OPERAND_WIDTH-1:0]      i_b_den,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [rgcd_pkg::NUM_W-1:0]    o_res_num,
    output logic [rgcd_pkg::DEN_W-1:0]    o_res_den,
    output logic                          o_is_equal
);

    // widths: operand, product, internal value (IW bits, at most 64), division counter
    localparam int OW = OPERAND_WIDTH;
    localparam int PW = 2 * OW;
    localparam int IW = (PW + 1 > 64) ? 64 : PW + 1;
    localparam int CW = $clog2(IW);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_GCD  = 3'd3;
    localparam logic [2:0] S_DIVX = 3'd4;
    localparam logic [2:0] S_DIVY = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]               r_state, n_state;
    rgcd_pkg::t_mode          r_mode, n_mode;
    logic [OW-1:0]            r_an, n_an, r_ad, n_ad, r_bn, n_bn, r_bd, n_bd;
    logic [1:0]               r_step, n_step;
    logic [PW-1:0]            r_prod, n_prod;
    logic [IW-1:0]            r_acc, n_acc;
    logic [IW-1:0]            r_x, n_x, r_y, n_y;      // numerator / denominator, later quotients
    logic [IW-1:0]            r_u, n_u, r_v, n_v;      // gcd working pair
    logic [IW-1:0]            r_rem, n_rem;
    logic                     r_com, n_com;            // still stripping common factors of two
    logic                     r_eq, n_eq;
    logic [CW-1:0]            r_cnt, n_cnt;
    logic                     r_out_valid, n_out_valid;
    logic [rgcd_pkg::NUM_W-1:0] r_res_num, n_res_num;
    logic [rgcd_pkg::DEN_W-1:0] r_res_den, n_res_den;
    logic                     r_res_eq, n_res_eq;

    // shared multiplier
    logic [OW-1:0] mul_a, mul_b;
    logic [PW-1:0] mul_p;

    always_comb begin
        mul_a = r_an;
        mul_b = r_bn;
        case (r_mode)
            rgcd_pkg::MODE_ADD: begin
                if (r_step == 2'd0) begin
                    mul_a = r_bd;
                    mul_b = r_an;
                end else if (r_step == 2'd1) begin
                    mul_a = r_ad;
                    mul_b = r_bn;
                end else begin
                    mul_a = r_ad;
                    mul_b = r_bd;
                end
            end
            rgcd_pkg::MODE_MUL: begin
                if (r_step == 2'd0) begin
                    mul_a = r_an;
                    mul_b = r_bn;
                end else begin
                    mul_a = r_ad;
                    mul_b = r_bd;
                end
            end
            default: begin
                // equality: cross products
                if (r_step == 2'd0) begin
                    mul_a = r_an;
                    mul_b = r_bd;
                end else begin
                    mul_a = r_bn;
                    mul_b = r_ad;
                end
            end
        endcase
    end

    assign mul_p = PW'(mul_a) * PW'(mul_b);

    // shared subtractor: gcd difference or division trial subtract
    logic [IW:0]   sub_a, sub_b;
    logic [IW+1:0] sub_full;
    logic [IW-1:0] sub_d;
    logic          sub_ge;
    logic          div_bit;

    assign div_bit = (r_state == S_DIVY) ? r_y[IW-1] : r_x[IW-1];

    always_comb begin
        if (r_state == S_GCD) begin
            sub_a = {1'b0, r_v};
        end else begin
            sub_a = {r_rem, div_bit};
        end
        sub_b = {1'b0, r_u};
    end

    assign sub_full = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ge   = ~sub_full[IW+1];
    assign sub_d    = sub_full[IW-1:0];

    // equality corner: a fraction with zero numerator or denominator stays as given
    logic unred, raw_eq;
    logic [1:0] last_step;

    assign unred  = (r_an == '0) || (r_ad == '0) || (r_bn == '0) || (r_bd == '0);
    assign raw_eq = (r_an == r_bn) && (r_ad == r_bd);
    assign last_step = (r_mode == rgcd_pkg::MODE_ADD) ? 2'd3 : 2'd2;

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_an        = r_an;
        n_ad        = r_ad;
        n_bn        = r_bn;
        n_bd        = r_bd;
        n_step      = r_step;
        n_prod      = r_prod;
        n_acc       = r_acc;
        n_x         = r_x;
        n_y         = r_y;
        n_u         = r_u;
        n_v         = r_v;
        n_rem       = r_rem;
        n_com       = r_com;
        n_eq        = r_eq;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_res_num   = r_res_num;
        n_res_den   = r_res_den;
        n_res_eq    = r_res_eq;

        // consumer takes the waiting word
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_mode = i_mode;
                    n_an   = i_a_num;
                    n_ad   = i_a_den;
                    n_bn   = i_b_num;
                    n_bd   = i_b_den;
                    n_eq   = 1'b0;
                    n_step = 2'd0;
                    unique case (i_mode) inside
                        rgcd_pkg::MODE_ADD, rgcd_pkg::MODE_MUL, rgcd_pkg::MODE_EQ: begin
                            n_state = S_MUL;
                        end
                        rgcd_pkg::MODE_INC: begin
                            n_x     = IW'(i_a_num) + IW'(i_a_den);
                            n_y     = IW'(i_a_den);
                            n_state = S_CHK;
                        end
                        default: begin
                            n_x     = IW'(i_a_num);
                            n_y     = IW'(i_a_den);
                            n_state = S_CHK;
                        end
                    endcase
                end
            end
            S_MUL: begin
                // issue product r_step, consume product r_step-1
                n_prod = mul_p;
                n_step = r_step + 2'd1;
                case (r_step)
                    2'd1: begin
                        if (r_mode == rgcd_pkg::MODE_MUL) begin
                            n_x = IW'(r_prod);
                        end else begin
                            n_acc = IW'(r_prod);
                        end
                    end
                    2'd2: begin
                        if (r_mode == rgcd_pkg::MODE_ADD) begin
                            n_x = r_acc + IW'(r_prod);
                        end else if (r_mode == rgcd_pkg::MODE_MUL) begin
                            n_y = IW'(r_prod);
                        end else begin
                            n_eq = unred ? raw_eq : (r_acc == IW'(r_prod));
                            n_x  = IW'(r_an);
                            n_y  = IW'(r_ad);
                        end
                    end
                    2'd3: begin
                        n_y = IW'(r_prod);
                    end
                    default: begin
                    end
                endcase
                if (r_step == last_step) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if ((r_x == '0) || (r_y == '0)) begin
                    n_state = S_OUT;
                end else begin
                    n_u     = r_x;
                    n_v     = r_y;
                    n_com   = 1'b1;
                    n_state = S_GCD;
                end
            end
            S_GCD: begin
                if (r_com) begin
                    // shared twos come out of the dividends as well
                    if (!r_u[0] && !r_v[0]) begin
                        n_u = r_u >> 1;
                        n_v = r_v >> 1;
                        n_x = r_x >> 1;
                        n_y = r_y >> 1;
                    end else begin
                        n_com = 1'b0;
                    end
                end else if (r_v == '0) begin
                    n_cnt   = '0;
                    n_rem   = '0;
                    n_state = S_DIVX;
                end else if (!r_u[0]) begin
                    n_u = r_u >> 1;
                end else if (!r_v[0]) begin
                    n_v = r_v >> 1;
                end else if (sub_ge) begin
                    n_v = sub_d;
                end else begin
                    n_u = r_v;
                    n_v = r_u;
                end
            end
            S_DIVX: begin
                n_x   = {r_x[IW-2:0], sub_ge};
                n_rem = sub_ge ? sub_d : sub_a[IW-1:0];
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(IW - 1)) begin
                    n_cnt   = '0;
                    n_rem   = '0;
                    n_state = S_DIVY;
                end
            end
            S_DIVY: begin
                n_y   = {r_y[IW-2:0], sub_ge};
                n_rem = sub_ge ? sub_d : sub_a[IW-1:0];
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(IW - 1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_res_num   = rgcd_pkg::NUM_W'(r_x);
                    n_res_den   = rgcd_pkg::DEN_W'(r_y);
                    n_res_eq    = r_eq;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_an      <= n_an;
        r_ad      <= n_ad;
        r_bn      <= n_bn;
        r_bd      <= n_bd;
        r_step    <= n_step;
        r_prod    <= n_prod;
        r_acc     <= n_acc;
        r_x       <= n_x;
        r_y       <= n_y;
        r_u       <= n_u;
        r_v       <= n_v;
        r_rem     <= n_rem;
        r_com     <= n_com;
        r_eq      <= n_eq;
        r_cnt     <= n_cnt;
        r_res_num <= n_res_num;
        r_res_den <= n_res_den;
        r_res_eq  <= n_res_eq;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_res_num   = r_res_num;
    assign o_res_den   = r_res_den;
    assign o_is_equal  = r_res_eq;

    // gcd pair never collapses to zero on the u side
    a_gcd_u_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GCD) |-> (r_u != '0))
        else $error("gcd operand u reached zero");

    // divisor is the odd part of the gcd
    a_div_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DIVX) || (r_state == S_DIVY)) |-> r_u[0])
        else $error("divisor not odd during division");

    // a new result only appears from the output state
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("result loaded outside output state");

endmodule

[bench/testbench.sv]
// self-checking bench for the rational alu with gcd reduction
`timescale 1ns / 100ps

module testbench;

    localparam int          OPERAND_W    = 16;
    localparam int unsigned LIMIT_CYCLES = 1_000_000;
    localparam int          TAIL_CYCLES  = 300;
    localparam int          RANDOM_WORDS = 700;

    // codes the package leaves unnamed: plain reduce and the spare codes
    localparam rgcd_pkg::t_mode MODE_RED  = 3'd4;
    localparam rgcd_pkg::t_mode MODE_RSV5 = 3'd5;
    localparam rgcd_pkg::t_mode MODE_RSV6 = 3'd6;
    localparam rgcd_pkg::t_mode MODE_RSV7 = 3'd7;

    typedef logic [OPERAND_W-1:0] t_opnd;

    typedef struct packed {
        rgcd_pkg::t_mode mode;
        t_opnd           a_num;
        t_opnd           a_den;
        t_opnd           b_num;
        t_opnd           b_den;
    } t_word;

    typedef struct packed {
        logic [rgcd_pkg::NUM_W-1:0] num;
        logic [rgcd_pkg::DEN_W-1:0] den;
        logic                       eq;
    } t_fraction;

    // keeps the reduced fractions still owed by the block, oldest first
    class t_ledger;
        t_fraction   pending[$];
        int unsigned fail_count = 0;

        function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
            longint unsigned t;
            while (y != 0) begin
                t = x % y;
                x = y;
                y = t;
            end
            return x;
        endfunction

        // zero numerator or denominator stays as given
        function automatic void reduce_frac(inout longint unsigned n, inout longint unsigned d);
            longint unsigned g;
            if (n != 0 && d != 0) begin
                g = gcd64(n, d);
                n = n / g;
                d = d / g;
            end
        endfunction

        function automatic void note_word(t_word w);
            longint unsigned an, ad, bn, bd, rn, rd;
            t_fraction f;
            an = 64'(w.a_num);
            ad = 64'(w.a_den);
            bn = 64'(w.b_num);
            bd = 64'(w.b_den);
            f.eq = 1'b0;
            case (w.mode)
                rgcd_pkg::MODE_ADD: begin
                    rn = bd * an + ad * bn;
                    rd = ad * bd;
                end
                rgcd_pkg::MODE_MUL: begin
                    rn = an * bn;
                    rd = ad * bd;
                end
                rgcd_pkg::MODE_INC: begin
                    rn = an + ad;
                    rd = ad;
                end
                default: begin
                    rn = an;
                    rd = ad;
                end
            endcase
            reduce_frac(rn, rd);
            if (w.mode == rgcd_pkg::MODE_EQ) begin
                reduce_frac(bn, bd);
                f.eq = (rn == bn && rd == bd);
            end
            f.num = rn[rgcd_pkg::NUM_W-1:0];
            f.den = rd[rgcd_pkg::DEN_W-1:0];
            pending.push_back(f);
        endfunction

        function automatic void check_result(logic [rgcd_pkg::NUM_W-1:0] num,
                                             logic [rgcd_pkg::DEN_W-1:0] den,
                                             logic eq);
            t_fraction want;
            if (pending.size() == 0) begin
                $display("%0t: result %0d/%0d eq %0b arrived with no word outstanding",
                         $time, num, den, eq);
                fail_count++;
                return;
            end
            want = pending.pop_front();
            if (num !== want.num) begin
                $display("%0t: res_num expected %0d actual %0d", $time, want.num, num);
                fail_count++;
            end
            if (den !== want.den) begin
                $display("%0t: res_den expected %0d actual %0d", $time, want.den, den);
                fail_count++;
            end
            if (eq !== want.eq) begin
                $display("%0t: is_equal expected %0b actual %0b", $time, want.eq, eq);
                fail_count++;
            end
        endfunction
    endclass

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_in_valid  = 1'b0;
    logic                       o_in_ready;
    rgcd_pkg::t_mode            i_mode      = rgcd_pkg::MODE_ADD;
    t_opnd                      i_a_num     = '0;
    t_opnd                      i_a_den     = '0;
    t_opnd                      i_b_num     = '0;
    t_opnd                      i_b_den     = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic [rgcd_pkg::NUM_W-1:0] o_res_num;
    logic [rgcd_pkg::DEN_W-1:0] o_res_den;
    logic                       o_is_equal;

    t_ledger ledger = new;
    bit      idle_on = 1'b1;

    rational_alu_gcd_reduce_core #(
        .OPERAND_WIDTH(OPERAND_W)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_a_num     (i_a_num),
        .i_a_den     (i_a_den),
        .i_b_num     (i_b_num),
        .i_b_den     (i_b_den),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res_num   (o_res_num),
        .o_res_den   (o_res_den),
        .o_is_equal  (o_is_equal)
    );

    always #4 i_clk = ~i_clk;

    function automatic t_word make_word(rgcd_pkg::t_mode m, int unsigned an, int unsigned ad,
                                        int unsigned bn, int unsigned bd);
        t_word w;
        w.mode  = m;
        w.a_num = an[OPERAND_W-1:0];
        w.a_den = ad[OPERAND_W-1:0];
        w.b_num = bn[OPERAND_W-1:0];
        w.b_den = bd[OPERAND_W-1:0];
        return w;
    endfunction

    task automatic send_word(input t_word w);
        int gap;
        gap = idle_on ? int'($urandom_range(0, 3)) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= w.mode;
        i_a_num    <= w.a_num;
        i_a_den    <= w.a_den;
        i_b_num    <= w.b_num;
        i_b_den    <= w.b_den;
        do @(posedge i_clk); while (!o_in_ready);
        ledger.note_word(w);
    endtask

    // hold off the sender until every outstanding result is back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (ledger.pending.size() != 0);
    endtask

    task automatic pick_fraction(output t_opnd num, output t_opnd den);
        int unsigned g;
        case ($urandom_range(0, 8))
            0, 1, 2, 3: begin
                num = t_opnd'($urandom_range(0, 65535));
                den = t_opnd'($urandom_range(1, 65535));
            end
            4, 5: begin
                num = t_opnd'($urandom_range(0, 20));
                den = t_opnd'($urandom_range(1, 20));
            end
            6, 7: begin
                // shared factor so the gcd has real work
                g   = $urandom_range(2, 255);
                num = t_opnd'(g * $urandom_range(0, 65535 / g));
                den = t_opnd'(g * $urandom_range(1, 65535 / g));
            end
            default: begin
                case ($urandom_range(0, 3))
                    0:       num = '0;
                    1:       num = 16'd1;
                    2:       num = 16'h8000;
                    default: num = 16'hFFFF;
                endcase
                case ($urandom_range(0, 3))
                    0:       den = 16'd1;
                    1:       den = 16'd2;
                    2:       den = 16'h8000;
                    default: den = 16'hFFFF;
                endcase
            end
        endcase
    endtask

    // two scalings of one small fraction, equal once reduced unless the numerator is zero
    task automatic pick_equal_pair(output t_opnd an, output t_opnd ad,
                                   output t_opnd bn, output t_opnd bd);
        int unsigned p, q, m, k1, k2;
        p  = $urandom_range(0, 255);
        q  = $urandom_range(1, 255);
        m  = (p > q) ? p : q;
        k1 = $urandom_range(1, 65535 / m);
        k2 = $urandom_range(1, 65535 / m);
        an = t_opnd'(p * k1);
        ad = t_opnd'(q * k1);
        bn = t_opnd'(p * k2);
        bd = t_opnd'(q * k2);
    endtask

    task automatic make_random_word(output t_word w);
        t_opnd an, ad, bn, bd;
        rgcd_pkg::t_mode m;
        m = rgcd_pkg::t_mode'($urandom_range(rgcd_pkg::MODE_ADD, MODE_RED));
        if (m == rgcd_pkg::MODE_EQ && $urandom_range(0, 1) == 1) begin
            pick_equal_pair(an, ad, bn, bd);
        end else begin
            pick_fraction(an, ad);
            pick_fraction(bn, bd);
        end
        w.mode  = m;
        w.a_num = an;
        w.a_den = ad;
        w.b_num = bn;
        w.b_den = bd;
    endtask

    // result side: random back-pressure, check each word taken
    initial begin
        int stall;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = idle_on ? int'($urandom_range(0, 3)) : 0;
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            ledger.check_result(o_res_num, o_res_den, o_is_equal);
        end
    end

    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        t_word w;
        int    n;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, every mode, zero numerators and denominators
        send_word(make_word(rgcd_pkg::MODE_ADD,  1, 2, 1, 3));
        send_word(make_word(rgcd_pkg::MODE_ADD,  65535, 65535, 65535, 65535));
        send_word(make_word(rgcd_pkg::MODE_ADD,  0, 5, 0, 7));
        send_word(make_word(rgcd_pkg::MODE_ADD,  0, 65535, 65535, 1));
        send_word(make_word(rgcd_pkg::MODE_MUL,  65535, 1, 65535, 1));
        send_word(make_word(rgcd_pkg::MODE_MUL,  0, 4, 3, 6));
        send_word(make_word(rgcd_pkg::MODE_MUL,  2, 3, 3, 2));
        send_word(make_word(rgcd_pkg::MODE_EQ,   1, 2, 2, 4));
        send_word(make_word(rgcd_pkg::MODE_EQ,   0, 6, 0, 3));
        send_word(make_word(rgcd_pkg::MODE_EQ,   0, 6, 0, 6));
        send_word(make_word(rgcd_pkg::MODE_EQ,   3, 7, 4, 7));
        send_word(make_word(rgcd_pkg::MODE_EQ,   65535, 65535, 1, 1));
        send_word(make_word(rgcd_pkg::MODE_INC,  65535, 65535, 0, 1));
        send_word(make_word(rgcd_pkg::MODE_INC,  0, 7, 12, 9));
        send_word(make_word(rgcd_pkg::MODE_INC,  65535, 1, 65535, 65535));
        send_word(make_word(MODE_RED,  6, 4, 1, 1));
        send_word(make_word(MODE_RED,  0, 6, 2, 5));
        send_word(make_word(MODE_RED,  65535, 3, 0, 65535));
        // spare codes act as a plain reduce
        send_word(make_word(MODE_RSV5, 12, 18, 5, 9));
        send_word(make_word(MODE_RSV6, 65535, 21845, 7, 1));
        send_word(make_word(MODE_RSV7, 0, 3, 0, 4));
        // zero denominators pass through unreduced
        send_word(make_word(MODE_RED,  5, 0, 1, 1));
        send_word(make_word(rgcd_pkg::MODE_ADD,  1, 0, 1, 2));
        send_word(make_word(rgcd_pkg::MODE_EQ,   2, 0, 1, 0));
        send_word(make_word(rgcd_pkg::MODE_MUL,  3, 0, 0, 5));
        wait_drained();

        for (n = 0; n < RANDOM_WORDS; n++) begin
            // stretches with and without idling on both sides
            if (n % 64 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            if (n == RANDOM_WORDS / 2)
                wait_drained();
            make_random_word(w);
            send_word(w);
        end
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (ledger.fail_count == 0 && ledger.pending.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
